// File: rtl/core/nsa_pkg.sv
// Shared types and constants for the navigation switch change and auto-repeat block.
package nsa_pkg;

  localparam int unsigned NUM_BTN = 5;

  // Button bit positions in masks and level words
  localparam int unsigned BTN_UP   = 0;
  localparam int unsigned BTN_DOWN = 1;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_REPEAT_DELAY = 2'd0,
    REG_REPEAT_RATE  = 2'd1,
    REG_EVENTS_EN    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_rate_ms;
    logic        events_enabled;
    logic        clear_held;     // one-cycle pulse on a write to a repeat register
  } cfg_t;

  typedef struct packed {
    logic [NUM_BTN-1:0] levels;
    logic [7:0]         elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [NUM_BTN-1:0] event_mask;
    logic [NUM_BTN-1:0] level_bits;
    logic [31:0]        prior_duration_ms;
    logic               is_repeat;
  } result_t;

endpackage

// File: rtl/core/nav_switch_change_and_auto_repeat.sv
// Top level: navigation switch change detector with auto-repeat.
//
// Input channel (in_valid/in_ready): one transaction per poll, carrying five
// debounced pressed levels and the milliseconds since the previous poll.
// Output channel (out_valid/out_ready): at most one event per poll, either a
// level change (mask of changed buttons, levels, prior duration) or an
// auto-repeat of the held up/down direction.
// Configuration: APB-style port, registers at 0x0 (repeat delay), 0x4 (repeat
// rate) and 0x8 (events enable); pready is tied high.
// Timing: a poll is captured in the input register, evaluated against the
// switch state once the output register is free or being taken, and its event
// lands in the output register; one poll is taken every cycle while the output
// is not stalled, as the event core commits its state for each poll taken.
// If the receiver stalls, one poll waits in the input register and a further
// poll is held off until the output register is taken.
// Reset (synchronous, rst_n low) clears all timers, levels, the held
// direction, the deadline and the configuration; both channels go empty.
module nav_switch_change_and_auto_repeat
  import nsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // poll input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_up_pressed,
  input  logic        in_down_pressed,
  input  logic        in_left_pressed,
  input  logic        in_right_pressed,
  input  logic        in_push_pressed,
  input  logic [7:0]  in_elapsed_ms,
  // event output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_event_mask,
  output logic [4:0]  out_level_bits,
  output logic [31:0] out_prior_duration_ms,
  output logic        out_is_repeat,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;
  logic    res_valid;
  result_t res;

  nsa_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Evaluate the held poll when the output register is free or being taken
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.levels     <= {in_push_pressed, in_right_pressed, in_left_pressed,
                               in_down_pressed, in_up_pressed};
      s1_item_r.elapsed_ms <= in_elapsed_ms;
    end
  end

  nsa_event_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (advance),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_mask        = out_res_r.event_mask;
  assign out_level_bits        = out_res_r.level_bits;
  assign out_prior_duration_ms = out_res_r.prior_duration_ms;
  assign out_is_repeat         = out_res_r.is_repeat;

endmodule

// File: rtl/core/nsa_apb_regs.sv
// APB-style configuration registers for the navigation switch block.
module nsa_apb_regs
  import nsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [15:0] delay_r;
  logic [15:0] rate_r;
  logic        ev_en_r;
  logic        wr_en;
  logic        wr_repeat;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // Drop the held direction at the same edge as a repeat register write
  assign wr_repeat = wr_en && ((idx == REG_REPEAT_DELAY) || (idx == REG_REPEAT_RATE));

  // Update the addressed register at the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= '0;
      rate_r  <= '0;
      ev_en_r <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (idx)
          REG_REPEAT_DELAY: begin
            delay_r <= pwdata[15:0];
          end
          REG_REPEAT_RATE: begin
            rate_r  <= pwdata[15:0];
          end
          REG_EVENTS_EN: begin
            ev_en_r <= pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_REPEAT_DELAY: prdata = {16'd0, delay_r};
      REG_REPEAT_RATE:  prdata = {16'd0, rate_r};
      REG_EVENTS_EN:    prdata = {31'd0, ev_en_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.repeat_delay_ms = delay_r;
  assign cfg.repeat_rate_ms  = rate_r;
  assign cfg.events_enabled  = ev_en_r;
  assign cfg.clear_held      = wr_repeat;

endmodule

// File: rtl/core/nsa_event_core.sv
// Switch state, change detection and repeat timing for one poll per cycle while step_en is high.
module nsa_event_core
  import nsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    step_en,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  logic [NUM_BTN-1:0] level_r,    level_nxt;
  logic [31:0]        since_r   [NUM_BTN];
  logic [31:0]        since_nxt [NUM_BTN];
  logic [31:0]        now_r,      now_nxt;
  logic [NUM_BTN-1:0] held_r,     held_nxt;
  logic [31:0]        deadline_r, deadline_nxt;

  logic [NUM_BTN-1:0] changed;
  logic [31:0]        duration;
  logic [31:0]        elapsed32;
  logic [31:0]        armed_deadline;
  logic [31:0]        lag;
  logic [32:0]        sum [NUM_BTN];
  logic               repeat_due;

  assign elapsed32 = {24'd0, item.elapsed_ms};
  assign now_nxt   = now_r + elapsed32;
  assign changed   = item.levels ^ level_r;
  assign level_nxt = item.levels;

  // Advance per-button timers; capture the last changed button's time
  always_comb begin
    duration = '0;
    for (int i = 0; i < NUM_BTN; i++) begin
      sum[i] = {1'b0, since_r[i]} + {1'b0, elapsed32};
      since_nxt[i] = sum[i][32] ? 32'hFFFF_FFFF : sum[i][31:0];
      if (changed[i]) begin
        duration     = since_nxt[i];
        since_nxt[i] = '0;
      end
    end
  end

  // Held direction: down wins over up; re-arm on any change of it
  always_comb begin
    held_nxt = '0;
    if (item.levels[BTN_DOWN]) begin
      held_nxt[BTN_DOWN] = 1'b1;
    end else if (item.levels[BTN_UP]) begin
      held_nxt[BTN_UP] = 1'b1;
    end
    armed_deadline = (held_nxt != held_r)
                     ? now_nxt + {16'd0, cfg.repeat_delay_ms} : deadline_r;
  end

  // Repeat check, wrap-safe
  assign lag        = now_nxt - armed_deadline;
  assign repeat_due = cfg.events_enabled && (changed == '0) && (held_nxt != '0)
                      && (cfg.repeat_rate_ms != '0) && !lag[31];
  assign deadline_nxt = repeat_due ? now_nxt + {16'd0, cfg.repeat_rate_ms}
                                   : armed_deadline;

  // Result of this poll
  always_comb begin
    res_valid = cfg.events_enabled && ((changed != '0) || repeat_due);
    if (changed != '0) begin
      res.event_mask        = changed;
      res.prior_duration_ms = duration;
      res.is_repeat         = 1'b0;
    end else begin
      res.event_mask        = held_nxt;
      res.prior_duration_ms = '0;
      res.is_repeat         = 1'b1;
    end
    res.level_bits = item.levels;
  end

  // Commit state when a poll is taken; drop the held mask on a repeat register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      now_r      <= '0;
      held_r     <= '0;
      deadline_r <= '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        since_r[i] <= '0;
      end
    end else begin
      if (step_en) begin
        level_r    <= level_nxt;
        now_r      <= now_nxt;
        held_r     <= held_nxt;
        deadline_r <= deadline_nxt;
        for (int i = 0; i < NUM_BTN; i++) begin
          since_r[i] <= since_nxt[i];
        end
      end
      if (cfg.clear_held) begin
        held_r <= '0;
      end
    end
  end

endmodule
